[src/sorted_set_insert_delete_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted set unit
// Concurrent check wrappers sampled on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSET_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SSET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSET_ASSERT(lbl, expr, msg)
`define SSET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/sset_pkg.sv]
// ----------------------------------------------------------------------------
// sset_pkg
// Shared constants and types of the sorted set unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sset_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int HELD_W       = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/sset_cell.sv]
// ----------------------------------------------------------------------------
// sset_cell
// One slot of the sorted chain: compares against the request key and
// shifts with its neighbors on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sset_cell
  import sset_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cell_ctl_t               ctl,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic signed [KEY_W-1:0] left_value,
  input  wire logic                    left_valid,
  input  wire logic                    left_lt,
  input  wire logic signed [KEY_W-1:0] right_value,
  input  wire logic                    right_valid,
  output logic signed [KEY_W-1:0]      value,
  output logic                         valid,
  output logic                         lt,
  output logic                         eq
);

  logic take_key;
  logic shift_up;
  logic shift_down;

  assign take_key   = ctl.ins_en && !lt && left_lt;
  assign shift_up   = ctl.ins_en && !lt && !left_lt;
  assign shift_down = ctl.del_en && !lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        lt <= valid && (value < key);
        eq <= valid && (value == key);
      end
      if (take_key) begin
        valid <= 1'b1;
      end else if (shift_up) begin
        valid <= left_valid;
      end else if (shift_down) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_key) begin
      value <= key;
    end else if (shift_up) begin
      value <= left_value;
    end else if (shift_down) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire

[src/sorted_set_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// sorted_set_insert_delete_unit
// Sorted set of distinct signed keys with insert and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser = request type (0 insert, 1 delete),
//   s_tdata = signed key. Output channel m_*: m_tuser = status
//   (0 done, 1 duplicate or absent, 2 full), m_tdata = held count.
//   Every request yields exactly one result.
//   A request is handled in order: the block latches it, every cell of the
//   chain compares its entry with the key, then the chain shifts and the
//   result register loads. s_tready is high only between requests, so the
//   block takes no new request before the last one is applied.
//   The result register parts the channels: a stalled m_tready lets the next
//   request be taken and compared; it is applied once the old result leaves.
//   Reset empties the set (valid bits cleared) and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_set_insert_delete_unit_defines.svh"

module sorted_set_insert_delete_unit
  import sset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [KEY_W-1:0] s_tdata,   // [31:0] key_value
  input  wire logic             s_tuser,   // [0] req_type
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // [4:0] held_count, [7:5] zero
  output logic [STATUS_W-1:0]   m_tuser    // [1:0] status_code
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

  state_t                  state;
  logic signed [KEY_W-1:0] key;
  logic                    req_type;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [STATUS_W-1:0]     status_next;
  logic [CW+HELD_W-1:0]    count_ext;

  logic signed [KEY_W-1:0] value_vec [CAPACITY];
  logic [CAPACITY-1:0]     valid_vec;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;

  cell_ctl_t ctl;
  logic      commit;
  logic      hit;
  logic      full;

  assign s_tready = (state == S_IDLE);
  assign commit   = (state == S_APPLY) && (!m_tvalid || m_tready);
  assign hit      = |eq_vec;
  assign full     = (count == CW'(CAPACITY));

  assign ctl.cmp_en = (state == S_CMP);
  assign ctl.ins_en = commit && (req_type == REQ_INSERT) && !hit && !full;
  assign ctl.del_en = commit && (req_type == REQ_DELETE) && hit;

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (req_type == REQ_INSERT) begin
      if (hit) begin
        status_next = ST_REJECT;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (!hit) begin
        status_next = ST_REJECT;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  assign count_ext = {{HELD_W{1'b0}}, count_next};

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] lv;
      logic                    lvd;
      logic                    llt;
      logic signed [KEY_W-1:0] rv;
      logic                    rvd;
      if (i == 0) begin : g_head
        assign lv  = key;
        assign lvd = 1'b1;
        assign llt = 1'b1;
      end else begin : g_mid
        assign lv  = value_vec[i-1];
        assign lvd = valid_vec[i-1];
        assign llt = lt_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign rv  = key;
        assign rvd = 1'b0;
      end else begin : g_body
        assign rv  = value_vec[i+1];
        assign rvd = valid_vec[i+1];
      end
      sset_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .key         (key),
        .left_value  (lv),
        .left_valid  (lvd),
        .left_lt     (llt),
        .right_value (rv),
        .right_valid (rvd),
        .value       (value_vec[i]),
        .valid       (valid_vec[i]),
        .lt          (lt_vec[i]),
        .eq          (eq_vec[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (commit) begin
            count    <= count_next;
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, count_ext[HELD_W-1:0]};
            m_tuser  <= status_next;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      key      <= s_tdata;
      req_type <= s_tuser;
    end
  end

  `SSET_ASSERT(a_count_range, count <= CW'(CAPACITY), "count above capacity")
  `SSET_ASSERT(a_valid_count, $countones(valid_vec) == int'(count), "valid bits disagree with count")
  `SSET_ASSERT(a_lt_prefix, (state != S_APPLY) || (((lt_vec >> 1) & ~lt_vec) == '0), "chain not sorted")
  `SSET_ASSERT(a_eq_onehot, (state != S_APPLY) || $onehot0(eq_vec), "key matched in two cells")
  `SSET_ASSERT_NEXT(a_ins_count, ctl.ins_en, count == $past(count) + 1'b1, "insert lost count")
  `SSET_ASSERT_NEXT(a_del_count, ctl.del_en, count == $past(count) - 1'b1, "delete lost count")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted set unit. A queue of insert and delete
// requests feeds a stream driver; every accepted request updates a shadow copy
// of the set, which yields the expected status and held count. The monitor
// compares each result in order against those expected results.
// ----------------------------------------------------------------------------
module tb_top;
  import sset_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int POOL_N      = 24;
  localparam int PHASES      = 11;
  localparam int PHASE_LEN   = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
  } set_request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   held;
  } set_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [KEY_W-1:0]    s_tdata  = '0;   // [31:0] key_value
  logic                s_tuser  = 1'b0; // [0] req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;         // [4:0] held_count, [7:5] zero
  logic [STATUS_W-1:0] m_tuser;         // [1:0] status_code

  set_request_t pending_q[$];
  set_result_t  result_q[$];

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int  shadow_count = 0;

  bit  req_taken    = 1'b0;
  int  req_cnt      = 0;
  int  rsp_cnt      = 0;
  int  fail_cnt     = 0;
  int  stall_cycles = 0;
  int  hold_cycles  = 0;
  bit  hold_done    = 1'b0;

  always #2 clk = ~clk;

  sorted_set_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic set_result_t apply_request(logic kind, logic signed [KEY_W-1:0] key);
    int          pos;
    bit          hit;
    set_result_t res;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < key) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == key);
    if (kind == REQ_INSERT) begin
      if (hit) begin
        res.status = ST_REJECT;
      end else if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = key;
        shadow_count++;
        res.status = ST_DONE;
      end
    end else begin
      if (!hit) begin
        res.status = ST_REJECT;
      end else begin
        for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_count--;
        res.status = ST_DONE;
      end
    end
    res.held = HELD_W'(shadow_count);
    return res;
  endfunction

  function automatic int idle_pct();
    if (req_cnt >= 800 && req_cnt < 1100) return 0;
    return 22;
  endfunction

  task automatic add_req(logic kind, logic [KEY_W-1:0] key);
    set_request_t r;
    r.kind = kind;
    r.key  = key;
    pending_q.push_back(r);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      req_taken = 1'b0;
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
        set_request_t r;
        r = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= r.key;
        s_tuser  <= r.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (!hold_done && rsp_cnt >= 300) begin
      hold_done   = 1'b1;
      hold_cycles = 100;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= idle_pct());
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        result_q.push_back(apply_request(s_tuser, s_tdata));
        req_taken = 1'b1;
        req_cnt++;
      end
      if (m_tvalid && m_tready) begin
        rsp_cnt++;
        if (result_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("ERROR: unexpected result status=%0d tdata=%0h", m_tuser, m_tdata);
        end else begin
          set_result_t exp_res;
          exp_res = result_q.pop_front();
          if (m_tuser !== exp_res.status || m_tdata !== {3'b000, exp_res.held}) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("ERROR: result %0d status exp %0d got %0d, held exp %0d got %0h",
                       rsp_cnt, exp_res.status, m_tuser, exp_res.held, m_tdata);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("sorted_set_insert_delete_unit test failed");
    $finish;
  end

  initial begin
    logic signed [KEY_W-1:0] key_pool [POOL_N];
    int  mode;
    int  ins_pct;
    logic [KEY_W-1:0] base;
    logic kind;
    logic [KEY_W-1:0] key;

    // directed: empty store, extremes, duplicates, full store
    add_req(REQ_DELETE, 32'd0);
    add_req(REQ_INSERT, 32'd0);
    add_req(REQ_INSERT, 32'h8000_0000);
    add_req(REQ_INSERT, 32'h7fff_ffff);
    add_req(REQ_INSERT, 32'hffff_ffff);
    add_req(REQ_INSERT, 32'd1);
    add_req(REQ_INSERT, 32'd0);
    add_req(REQ_DELETE, 32'd5);
    for (int i = 2; i <= 12; i++) add_req(REQ_INSERT, KEY_W'(i));
    add_req(REQ_INSERT, 32'd7);
    add_req(REQ_INSERT, 32'd100);
    add_req(REQ_DELETE, 32'h7fff_ffff);
    add_req(REQ_DELETE, 32'h8000_0000);
    add_req(REQ_DELETE, 32'd0);

    // random phases over a small pool of keys, each ending in a full drain
    for (int ph = 0; ph < PHASES; ph++) begin
      mode    = $urandom_range(0, 2);
      ins_pct = $urandom_range(35, 85);
      base    = $urandom;
      for (int i = 0; i < POOL_N; i++) begin
        if (ph == 0 && i == 0)
          key_pool[i] = -1;
        else if (ph == 0 && i < 13)
          key_pool[i] = i;
        else if (mode == 0)
          key_pool[i] = $urandom;
        else if (mode == 1)
          key_pool[i] = base + $urandom_range(0, 40);
        else if (i == 0)
          key_pool[i] = 32'h8000_0000;
        else if (i == 1)
          key_pool[i] = 32'h7fff_ffff;
        else
          key_pool[i] = $urandom_range(0, 40) - 20;
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
        if (kind == REQ_DELETE && $urandom_range(0, 99) < 5)
          key = $urandom;
        else
          key = key_pool[$urandom_range(0, POOL_N - 1)];
        add_req(kind, key);
      end
      for (int i = POOL_N - 1; i >= 0; i--) add_req(REQ_DELETE, key_pool[i]);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("sorted_set_insert_delete_unit test passed");
    end else begin
      $display("sorted_set_insert_delete_unit test failed");
    end
    $finish;
  end

endmodule
